/* hdl/tns_pkg.sv */
package tns_pkg;

    // Store and field sizes
    localparam int MAX_KEEP     = 16;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int LIMIT_BITS   = 5;
    localparam int LIMIT_RESET  = 16;

    // Count of held rows, 0 .. MAX_KEEP
    localparam int CNT_BITS = $clog2(MAX_KEEP + 1);
    // Common width for comparing the limit register against the store size
    localparam int CMP_BITS = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;

    // Item kinds
    localparam logic KIND_ROW = 1'b0;
    localparam logic KIND_EOG = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    // Per-slot control from the top level
    typedef struct packed {
        logic ins;       // sorted insert of the broadcast row
        logic shift;     // move every entry one slot toward slot 0
        logic occupied;  // slot holds a live row
        logic in_range;  // slot index below the effective limit
    } t_slot_ctl;

endpackage

/* hdl/tns_in_if.sv */
interface tns_in_if ();
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [tns_pkg::KEY_BITS-1:0]      row_key;
    logic [tns_pkg::PAYLOAD_BITS-1:0]  row_payload;

    modport source (output valid, output kind, output row_key, output row_payload,
                    input ready);
    modport sink   (input valid, input kind, input row_key, input row_payload,
                    output ready);
endinterface

/* hdl/tns_out_if.sv */
interface tns_out_if ();
    logic                              valid;
    logic                              ready;
    logic [tns_pkg::KEY_BITS-1:0]      out_key;
    logic [tns_pkg::PAYLOAD_BITS-1:0]  out_payload;
    logic                              last_of_group;

    modport source (output valid, output out_key, output out_payload,
                    output last_of_group, input ready);
    modport sink   (input valid, input out_key, input out_payload,
                    input last_of_group, output ready);
endinterface

/* hdl/top_n_selector_core.sv */
// channel  | dir | handshake      | word
// ---------+-----+----------------+---------------------------------------------
// i_row    | in  | valid / ready  | kind, row_key, row_payload
// o_sel    | out | valid / ready  | out_key, out_payload, last_of_group
// i_cfg_*  | in  | write enable   | keep_limit (5 bits)
//
// A data row is compared against all slots of the chain at once and the insert
// shifts the tail up by one slot in the same edge.
// An end-of-group word starts a drain, one held row per step, while the chain
// shifts toward slot 0 and feeds the output register; i_row.ready stays low then.
// Output stalls hold the drain; the last row may wait in the output register while
// new rows are taken.
// Reset (synchronous) empties the store and sets the limit to 16; slot data is not cleared.
module top_n_selector_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tns_in_if.sink                              i_row,
    tns_out_if.source                           o_sel,
    input  logic                                i_cfg_we,
    input  logic [tns_pkg::LIMIT_BITS-1:0]      i_cfg_wdata
);

    localparam int N   = tns_pkg::MAX_KEEP;
    localparam int CW  = tns_pkg::CNT_BITS;
    localparam int CPW = tns_pkg::CMP_BITS;

    tns_pkg::t_state                   r_state;
    tns_pkg::t_state                   n_state;
    logic [tns_pkg::LIMIT_BITS-1:0]    r_keep_limit;
    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     n_count;

    logic                              r_out_valid;
    logic [tns_pkg::KEY_BITS-1:0]      r_out_key;
    logic [tns_pkg::PAYLOAD_BITS-1:0]  r_out_pay;
    logic                              r_out_last;

    logic [CW-1:0]                     lim;
    logic [CW-1:0]                     eff_count;
    logic                              in_fire;
    logic                              ins;
    logic                              out_free;
    logic                              drain_step;
    logic                              insert_any;

    tns_pkg::t_slot_ctl                slot_ctl [N];
    logic [N-1:0]                      slot_le;
    logic [N-1:0]                      slot_take;
    logic [tns_pkg::KEY_BITS-1:0]      slot_key [N];
    logic [tns_pkg::PAYLOAD_BITS-1:0]  slot_pay [N];

    // Effective limit saturates at the store size; count is cut down to it
    always_comb begin
        if (CPW'(r_keep_limit) > CPW'(N)) begin
            lim = CW'(N);
        end else begin
            lim = CW'(r_keep_limit);
        end
        eff_count = (r_count > lim) ? lim : r_count;
    end

    assign i_row.ready = (r_state == tns_pkg::ST_IDLE);
    assign in_fire     = i_row.valid && i_row.ready;
    assign ins         = in_fire && (i_row.kind == tns_pkg::KIND_ROW);
    assign out_free    = !r_out_valid || o_sel.ready;
    assign drain_step  = (r_state == tns_pkg::ST_DRAIN) && out_free;

    // Row of slots: each talks to its lower and upper neighbor and sees the broadcast row
    for (genvar g = 0; g < N; g++) begin : g_slot
        assign slot_ctl[g].ins      = ins;
        assign slot_ctl[g].shift    = drain_step;
        assign slot_ctl[g].occupied = CW'(g) < eff_count;
        assign slot_ctl[g].in_range = CW'(g) < lim;
        assign slot_take[g]         = slot_ctl[g].in_range && !slot_le[g];

        if (g == 0) begin : g_head
            tns_slot u_slot (
                .i_clk      (i_clk),
                .i_ctl      (slot_ctl[g]),
                .i_new_key  (i_row.row_key),
                .i_new_pay  (i_row.row_payload),
                .i_prev_le  (1'b1),
                .i_prev_key (i_row.row_key),
                .i_prev_pay (i_row.row_payload),
                .i_next_key (slot_key[(g + 1) % N]),
                .i_next_pay (slot_pay[(g + 1) % N]),
                .o_le       (slot_le[g]),
                .o_key      (slot_key[g]),
                .o_pay      (slot_pay[g])
            );
        end else begin : g_body
            tns_slot u_slot (
                .i_clk      (i_clk),
                .i_ctl      (slot_ctl[g]),
                .i_new_key  (i_row.row_key),
                .i_new_pay  (i_row.row_payload),
                .i_prev_le  (slot_le[g - 1]),
                .i_prev_key (slot_key[g - 1]),
                .i_prev_pay (slot_pay[g - 1]),
                .i_next_key (slot_key[(g + 1 < N) ? g + 1 : g]),
                .i_next_pay (slot_pay[(g + 1 < N) ? g + 1 : g]),
                .o_le       (slot_le[g]),
                .o_key      (slot_key[g]),
                .o_pay      (slot_pay[g])
            );
        end
    end

    // Row lands somewhere below the limit, else it is dropped
    assign insert_any = |slot_take;

    // Next state and count
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            tns_pkg::ST_IDLE: begin
                if (in_fire && (i_row.kind == tns_pkg::KIND_EOG)) begin
                    n_count = eff_count;
                    if (eff_count != '0) begin
                        n_state = tns_pkg::ST_DRAIN;
                    end
                end else if (ins) begin
                    n_count = eff_count;
                    if (insert_any && (eff_count < lim)) begin
                        n_count = eff_count + CW'(1);
                    end
                end
            end
            tns_pkg::ST_DRAIN: begin
                if (drain_step) begin
                    n_count = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_state = tns_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = tns_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tns_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold count and limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_keep_limit <= tns_pkg::LIMIT_BITS'(tns_pkg::LIMIT_RESET);
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                r_keep_limit <= i_cfg_wdata;
            end
        end
    end

    // Output register: load from slot 0 on each drain step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (drain_step) begin
            r_out_valid <= 1'b1;
        end else if (o_sel.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain_step) begin
            r_out_key  <= slot_key[0];
            r_out_pay  <= slot_pay[0];
            r_out_last <= (r_count == CW'(1));
        end
    end

    assign o_sel.valid         = r_out_valid;
    assign o_sel.out_key       = r_out_key;
    assign o_sel.out_payload   = r_out_pay;
    assign o_sel.last_of_group = r_out_last;

endmodule

/* hdl/tns_slot.sv */
module tns_slot (
    input  logic                             i_clk,
    input  tns_pkg::t_slot_ctl               i_ctl,
    input  logic [tns_pkg::KEY_BITS-1:0]     i_new_key,
    input  logic [tns_pkg::PAYLOAD_BITS-1:0] i_new_pay,
    input  logic                             i_prev_le,
    input  logic [tns_pkg::KEY_BITS-1:0]     i_prev_key,
    input  logic [tns_pkg::PAYLOAD_BITS-1:0] i_prev_pay,
    input  logic [tns_pkg::KEY_BITS-1:0]     i_next_key,
    input  logic [tns_pkg::PAYLOAD_BITS-1:0] i_next_pay,
    output logic                             o_le,
    output logic [tns_pkg::KEY_BITS-1:0]     o_key,
    output logic [tns_pkg::PAYLOAD_BITS-1:0] o_pay
);

    logic [tns_pkg::KEY_BITS-1:0]     r_key;
    logic [tns_pkg::PAYLOAD_BITS-1:0] r_pay;
    logic [tns_pkg::KEY_BITS-1:0]     n_key;
    logic [tns_pkg::PAYLOAD_BITS-1:0] n_pay;
    logic                             le;

    // Live entry that ranks at or before the new row: it stays put
    assign le = i_ctl.occupied && (r_key <= i_new_key);

    // Pick next contents: drain shift, or insert (new row at the boundary, else push up)
    always_comb begin
        n_key = r_key;
        n_pay = r_pay;
        if (i_ctl.shift) begin
            n_key = i_next_key;
            n_pay = i_next_pay;
        end else if (i_ctl.ins && i_ctl.in_range && !le) begin
            if (i_prev_le) begin
                n_key = i_new_key;
                n_pay = i_new_pay;
            end else begin
                n_key = i_prev_key;
                n_pay = i_prev_pay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pay <= n_pay;
    end

    assign o_le  = le;
    assign o_key = r_key;
    assign o_pay = r_pay;

endmodule

/* hdl/tns_checker.sv */
module tns_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_in_kind,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [tns_pkg::KEY_BITS-1:0]     i_out_key,
    input logic                             i_out_last
);

    // Output empties right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_key)
            && $stable(i_out_last))
        else $error("stalled output word changed");

    // No new item while a group is still draining
    a_drain_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input taken during drain");

    // A data row never produces output
    a_row_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_kind == tns_pkg::KIND_ROW) && !i_out_valid
            |=> !i_out_valid)
        else $error("output after data row");

endmodule

bind top_n_selector_core tns_checker u_tns_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_row.valid),
    .i_in_ready  (i_row.ready),
    .i_in_kind   (i_row.kind),
    .i_out_valid (o_sel.valid),
    .i_out_ready (o_sel.ready),
    .i_out_key   (o_sel.out_key),
    .i_out_last  (o_sel.last_of_group)
);
